### rtl/core/co2_sensor_uart_poll_engine_macros.svh
// Assertion helpers for the CO2 poll engine.
`ifndef CO2_SENSOR_UART_POLL_ENGINE_MACROS_SVH
`define CO2_SENSOR_UART_POLL_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, masked while reset is high.
`define CO2P_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define CO2P_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CO2P_ASSERT(lbl, clk, rst, prop, msg)
`define CO2P_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/core/co2poll_pkg.sv
package co2poll_pkg;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_BYTE  = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_SYNC  = 2'd1,
      PH_FRAME = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_LINK   = 3'd1,
      ST_SYNC_TO   = 3'd2,
      ST_SHORT     = 3'd3,
      ST_CSUM_BAD  = 3'd4,
      ST_RANGE     = 3'd5
   } status_type;

   typedef enum logic {
      KIND_TX      = 1'b0,
      KIND_OUTCOME = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      CMD_NONE   = 2'd0,
      CMD_READ   = 2'd1,
      CMD_CALOFF = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_LINK_EN   = 2'd0,
      CSR_SYNC_TO   = 2'd1,
      CSR_BYTE_TO   = 2'd2,
      CSR_MAX_PPM   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  tx_byte;
      logic [15:0] ppm;
      logic [2:0]  status;
      logic        last;
   } rsp_payload_type;

   // One burst of results handed to the emitter.
   typedef struct packed {
      cmd_type     cmd;
      logic        has_outcome;
      status_type  status;
      logic [15:0] ppm;
   } job_type;

   localparam logic [7:0]  START_BYTE     = 8'hFF;
   localparam logic [3:0]  FRAME_LAST_IDX = 4'd8;
   localparam logic [3:0]  CMD_LAST_IDX   = 4'd8;
   localparam logic [3:0]  OUTCOME_IDX    = 4'd9;
   localparam logic [15:0] SYNC_TO_RESET  = 16'd2000;
   localparam logic [15:0] BYTE_TO_RESET  = 16'd2000;
   localparam logic [15:0] MAX_PPM_RESET  = 16'd50000;

   localparam logic [7:0] READ_CMD [9] =
      '{8'hFF, 8'h01, 8'h86, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h79};
   localparam logic [7:0] CALOFF_CMD [9] =
      '{8'hFF, 8'h01, 8'h79, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h86};

   function automatic logic [7:0] cmd_byte(input cmd_type cmd, input logic [3:0] idx);
      logic [7:0] b;
      b = 8'h00;
      if (idx <= CMD_LAST_IDX) begin
         case (cmd)
            CMD_READ:   b = READ_CMD[idx];
            CMD_CALOFF: b = CALOFF_CMD[idx];
            default:    b = 8'h00;
         endcase
      end
      return b;
   endfunction

endpackage

### rtl/core/co2poll_emit.sv
`include "co2_sensor_uart_poll_engine_macros.svh"

module co2poll_emit
   import co2poll_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  job_type         job,
   output logic            free,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   logic       valid_ff, valid_in;
   job_type    job_ff, job_in;
   logic [3:0] idx_ff, idx_in;
   logic       is_byte;
   logic       last_w;
   logic       take_w;

   assign is_byte = (idx_ff <= CMD_LAST_IDX);
   // last of a command-only burst is its ninth byte, otherwise the outcome
   assign last_w  = (idx_ff == OUTCOME_IDX) ||
                    ((idx_ff == CMD_LAST_IDX) && !job_ff.has_outcome);
   assign take_w  = valid_ff && rsp_ready;
   assign free    = !valid_ff || (take_w && last_w);

   always_comb begin
      valid_in = valid_ff;
      job_in   = job_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         job_in   = job;
         idx_in   = (job.cmd == CMD_NONE) ? OUTCOME_IDX : 4'd0;
      end else if (take_w) begin
         if (last_w) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 4'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      job_ff <= job_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_data.kind    = is_byte ? KIND_TX : KIND_OUTCOME;
   assign rsp_data.tx_byte = is_byte ? cmd_byte(job_ff.cmd, idx_ff) : 8'h00;
   assign rsp_data.ppm     = is_byte ? 16'h0000 : job_ff.ppm;
   assign rsp_data.status  = is_byte ? ST_OK : job_ff.status;
   assign rsp_data.last    = last_w;

   `CO2P_ASSERT(a_load_when_free, clock, reset, load |-> free, "burst overwritten")
   `CO2P_ASSERT(a_burst_continues, clock, reset, (take_w && !last_w) |=> rsp_valid, "burst cut short")
   `CO2P_ASSERT(a_outcome_is_last, clock, reset, (valid_ff && !is_byte) |-> last_w, "outcome not last")
   `CO2P_ASSERT_ALWAYS(a_idx_range, clock, valid_ff |-> (idx_ff <= OUTCOME_IDX), "index out of range")

endmodule

### rtl/core/co2_sensor_uart_poll_engine.sv
// CO2 sensor poll engine. Items arrive on req_ (op: start, received byte, 1 ms
// tick) and are decoded in the cycle they are accepted; results leave on rsp_,
// one per ready cycle, with last marking the final result of an item. Ticks and
// all bytes but the one that closes a frame give at most one result; a start
// (link on) gives the 9-byte read command; the byte that closes the first good
// frame gives the 9-byte calibration-off command plus the outcome (10 results).
// req_ready is low while any result of an earlier item waits, and rises in the
// cycle the final one is taken, so with the receiver ready, items that give one
// result or none stream at one per cycle, and a burst in the emitter's single
// result register holds the input until its final result is taken. Only checksum
// and the two reading bytes are kept from a frame (running sum). Configuration
// writes are taken every cycle (csr_ready is always high).
`include "co2_sensor_uart_poll_engine_macros.svh"

module co2_sensor_uart_poll_engine
   import co2poll_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  csr_index_type   csr_index,
   input  logic [15:0]     csr_wdata
);

   // configuration
   logic        link_en_ff, link_en_in;
   logic [15:0] sync_to_ff, sync_to_in;
   logic [15:0] byte_to_ff, byte_to_in;
   logic [15:0] max_ppm_ff, max_ppm_in;

   // read state
   phase_type   phase_ff, phase_in;
   logic [3:0]  count_ff, count_in;
   logic [15:0] wait_ff, wait_in;
   logic        cal_sent_ff, cal_sent_in;
   logic [7:0]  sum_ff, sum_in;     // sum of frame bytes 1..count-1
   logic [7:0]  hi_ff, hi_in;       // frame byte 2
   logic [7:0]  lo_ff, lo_in;       // frame byte 3

   logic        accept;
   logic        csr_wr;
   logic        emit_free;
   logic        load_w;
   job_type     job_w;
   logic [15:0] tick_w;
   logic [15:0] limit_w;
   logic [15:0] value_w;
   logic [7:0]  b;

   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign req_ready = emit_free;
   assign b         = req_data.rx_byte;

   // tick counter saturates at all ones
   assign tick_w  = (wait_ff == 16'hFFFF) ? 16'hFFFF : (wait_ff + 16'd1);
   assign limit_w = (phase_ff == PH_SYNC) ? sync_to_ff : byte_to_ff;
   assign value_w = {hi_ff, lo_ff};

   always_comb begin
      link_en_in  = link_en_ff;
      sync_to_in  = sync_to_ff;
      byte_to_in  = byte_to_ff;
      max_ppm_in  = max_ppm_ff;
      phase_in    = phase_ff;
      count_in    = count_ff;
      wait_in     = wait_ff;
      cal_sent_in = cal_sent_ff;
      sum_in      = sum_ff;
      hi_in       = hi_ff;
      lo_in       = lo_ff;
      load_w      = 1'b0;
      job_w       = '{cmd: CMD_NONE, has_outcome: 1'b1, status: ST_OK, ppm: 16'h0000};

      if (accept) begin
         case (req_data.op)
            OP_START: begin
               if (!link_en_ff) begin
                  cal_sent_in  = 1'b0;
                  phase_in     = PH_IDLE;
                  load_w       = 1'b1;
                  job_w.status = ST_NO_LINK;
               end else begin
                  // restarts any read in progress
                  load_w            = 1'b1;
                  job_w.cmd         = CMD_READ;
                  job_w.has_outcome = 1'b0;
                  phase_in          = PH_SYNC;
                  count_in          = 4'd0;
                  wait_in           = 16'd0;
               end
            end
            OP_BYTE: begin
               if (phase_ff == PH_SYNC) begin
                  if (b == START_BYTE) begin
                     count_in = 4'd1;
                     wait_in  = 16'd0;
                     sum_in   = 8'h00;
                     phase_in = PH_FRAME;
                  end
               end else if (phase_ff == PH_FRAME) begin
                  count_in = count_ff + 4'd1;
                  wait_in  = 16'd0;
                  if (count_ff == 4'd2) hi_in = b;
                  if (count_ff == 4'd3) lo_in = b;
                  if (count_ff < FRAME_LAST_IDX) sum_in = sum_ff + b;
                  if (count_ff == FRAME_LAST_IDX) begin
                     // frame complete: byte 8 must cancel the sum of bytes 1..7
                     phase_in = PH_IDLE;
                     load_w   = 1'b1;
                     if (8'(sum_ff + b) != 8'h00) begin
                        job_w.status = ST_CSUM_BAD;
                     end else if (value_w > max_ppm_ff) begin
                        job_w.status = ST_RANGE;
                     end else begin
                        job_w.ppm = value_w;
                        if (!cal_sent_ff) begin
                           job_w.cmd   = CMD_CALOFF;
                           cal_sent_in = 1'b1;
                        end
                     end
                  end
               end
            end
            OP_TICK: begin
               if (phase_ff == PH_SYNC || phase_ff == PH_FRAME) begin
                  wait_in = tick_w;
                  if (tick_w >= limit_w) begin
                     load_w       = 1'b1;
                     job_w.status = (phase_ff == PH_SYNC) ? ST_SYNC_TO : ST_SHORT;
                     phase_in     = PH_IDLE;
                  end
               end
            end
            default: ;  // unused op: ignored
         endcase
      end

      if (csr_wr) begin
         unique case (csr_index)
            CSR_LINK_EN: begin
               if (!csr_wdata[0]) begin
                  phase_in    = PH_IDLE;
                  cal_sent_in = 1'b0;
               end else if (!link_en_ff) begin
                  cal_sent_in = 1'b0;
               end
               link_en_in = csr_wdata[0];
            end
            CSR_SYNC_TO: sync_to_in = csr_wdata;
            CSR_BYTE_TO: byte_to_in = csr_wdata;
            CSR_MAX_PPM: max_ppm_in = csr_wdata;
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_en_ff  <= 1'b0;
         sync_to_ff  <= SYNC_TO_RESET;
         byte_to_ff  <= BYTE_TO_RESET;
         max_ppm_ff  <= MAX_PPM_RESET;
         phase_ff    <= PH_IDLE;
         count_ff    <= 4'd0;
         wait_ff     <= 16'd0;
         cal_sent_ff <= 1'b0;
      end else begin
         link_en_ff  <= link_en_in;
         sync_to_ff  <= sync_to_in;
         byte_to_ff  <= byte_to_in;
         max_ppm_ff  <= max_ppm_in;
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         wait_ff     <= wait_in;
         cal_sent_ff <= cal_sent_in;
      end
      sum_ff <= sum_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
   end

   co2poll_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (load_w),
      .job       (job_w),
      .free      (emit_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `CO2P_ASSERT(a_frame_count, clock, reset, (phase_ff == PH_FRAME) |-> (count_ff >= 4'd1 && count_ff <= FRAME_LAST_IDX), "frame count out of range")
   `CO2P_ASSERT(a_cal_needs_link, clock, reset, cal_sent_ff |-> link_en_ff, "calibration flag without link")
   `CO2P_ASSERT(a_start_busy, clock, reset, (accept && req_data.op == OP_START && link_en_ff) |=> (rsp_valid && !req_ready), "read command not emitted")

endmodule
